// ----- design/rpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants for the reverse pair counter
// Payload structs for the value and result channels plus default sizing.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int unsigned DefMaxElems = 1024;
  localparam int unsigned CountW      = 19;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned QueueDepth  = 2;

  typedef struct packed {
    logic signed [ValueW-1:0] value_in;
    logic                     is_last;
  } rpc_in_t;

  typedef struct packed {
    logic [CountW-1:0] pair_count;
    logic              overflowed;
  } rpc_out_t;

  // Classified item handed from the front end to the scan engine
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     keep;     // element fits in the store
    logic                     is_last;
  } rpc_job_t;

endpackage

// ----- design/rpc_front.sv -----
// ----------------------------------------------------------------------------
// rpc_front: intake and classification
// Accepts values, marks each as kept or dropped against the fill count, and
// pushes classified jobs into a small queue toward the scan engine.
// ----------------------------------------------------------------------------
module rpc_front
  import rpc_pkg::*;
#(
  parameter int unsigned MAX_ELEMS = DefMaxElems
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rpc_in_t  in_data,
  output logic     job_valid,
  input  logic     job_pop,
  output rpc_job_t job_data
);

  localparam int unsigned CntW = $clog2(MAX_ELEMS + 1);
  localparam int unsigned PtrW = $clog2(QueueDepth);

  rpc_job_t         q_r [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PtrW:0]    used_r;
  logic [CntW-1:0]  fill_r;
  logic             push;

  assign in_stall  = (used_r == (PtrW+1)'(QueueDepth));
  assign push      = in_valid && !in_stall;
  assign job_valid = (used_r != '0);
  assign job_data  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r].value   <= in_data.value_in;
      q_r[wr_ptr_r].is_last <= in_data.is_last;
      q_r[wr_ptr_r].keep    <= (fill_r < CntW'(MAX_ELEMS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      used_r   <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PtrW'(1);
        if (in_data.is_last) begin
          fill_r <= '0;
        end else if (fill_r < CntW'(MAX_ELEMS)) begin
          fill_r <= fill_r + CntW'(1);
        end
      end
      if (job_pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      used_r <= used_r + (PtrW+1)'(push) - (PtrW+1)'(job_pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job_valid) else $error("pop from empty queue");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CntW'(MAX_ELEMS)) else $error("fill count past capacity");
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= (PtrW+1)'(QueueDepth)) else $error("queue overrun");

endmodule

// ----- design/rpc_scan.sv -----
// ----------------------------------------------------------------------------
// rpc_scan: scan engine
// For each kept value, sweeps the element memory one entry a cycle counting
// stored values above twice the new one, then appends the value. On the
// final item it posts the total to an output register.
// ----------------------------------------------------------------------------
module rpc_scan
  import rpc_pkg::*;
#(
  parameter int unsigned MAX_ELEMS = DefMaxElems
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_valid,
  output logic     job_pop,
  input  rpc_job_t job_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rpc_out_t out_data
);

  localparam int unsigned AddrW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ELEMS + 1);
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_POST  = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic signed [ValueW-1:0] mem [MAX_ELEMS];
  logic signed [ValueW-1:0] rd_data_r;
  logic signed [ValueW+1:0] twice_r;
  logic [CntW-1:0]          total_r;
  logic [CntW-1:0]          idx_r;
  logic                     rd_vld_r;
  logic [CountW-1:0]        pairs_r;
  logic                     drop_r;
  logic                     last_r;
  logic signed [ValueW-1:0] val_r;
  logic                     out_valid_r;
  rpc_out_t                 out_data_r;
  logic                     hit;
  logic [CountW:0]          sum;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign hit  = rd_vld_r && ((ValueW+2)'(rd_data_r) > twice_r);
  assign sum  = {1'b0, pairs_r} + (CountW+1)'(hit);
  assign job_pop = (state_r == ST_IDLE) && job_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          if (job_data.keep) state_nxt = ST_SCAN;
          else if (job_data.is_last) state_nxt = ST_POST;
        end
      end
      ST_SCAN:  if (idx_r == total_r) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = last_r ? ST_POST : ST_IDLE;
      ST_POST:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // memory read port, registered
  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN && idx_r != total_r) begin
      rd_data_r <= mem[idx_r[AddrW-1:0]];
    end
    if (state_r == ST_DRAIN) begin
      mem[total_r[AddrW-1:0]] <= val_r;
    end
    if (job_pop) begin
      val_r   <= job_data.value;
      twice_r <= {{2{job_data.value[ValueW-1]}}, job_data.value} <<< 1;
      last_r  <= job_data.is_last;
    end
    if (state_r == ST_POST && (!out_valid_r || !out_stall)) begin
      out_data_r.pair_count <= pairs_r;
      out_data_r.overflowed <= drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      pairs_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == ST_SCAN) && (idx_r != total_r);
      if (rd_vld_r) begin
        pairs_r <= sum[CountW] ? CountMax : sum[CountW-1:0];
      end
      if (state_r == ST_POST && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          idx_r <= '0;
          if (job_valid && !job_data.keep) drop_r <= 1'b1;
        end
        ST_SCAN: if (idx_r != total_r) idx_r <= idx_r + CntW'(1);
        ST_DRAIN: total_r <= total_r + CntW'(1);
        ST_POST: begin
          if (!out_valid_r || !out_stall) begin
            total_r <= '0;
            pairs_r <= '0;
            drop_r  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CntW'(MAX_ELEMS)) else $error("store count past capacity");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> idx_r <= total_r) else $error("scan past fill");
  a_post_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> total_r == '0 && pairs_r == '0)
    else $error("state not cleared after result");

endmodule

// ----- design/reverse_pair_counter.sv -----
// ----------------------------------------------------------------------------
// reverse_pair_counter: count reverse pairs over a stream of signed values
// ----------------------------------------------------------------------------
// Feed one signed 32-bit value per in_ transaction; in_data.is_last ends a
// sequence. A pair (i, j), i earlier, counts when value_i > 2 * value_j at
// 34-bit width. After the last value one out_ transaction carries the total
// count (saturating) and an overflow flag, and the store clears.
// Up to MAX_ELEMS values are kept; later ones are dropped and flagged.
// A kept value is swept in the scan engine against every value already
// stored, the single-port element memory being read one entry per cycle;
// a dropped value skips the sweep, and the last item adds a post step for
// its result.
// A two-entry queue decouples intake from the scan engine, so in_stall
// rises only when it is full. The result sits in an output register; a
// stalled result holds, and the engine waits in its post step until taken.
// Reset (rst_n low, synchronous) empties the queue, clears counts and
// flags; the element memory itself needs no clearing.
// ----------------------------------------------------------------------------
module reverse_pair_counter
  import rpc_pkg::*;
#(
  parameter int unsigned MAX_ELEMS = DefMaxElems
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rpc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rpc_out_t out_data
);

  logic     job_valid, job_pop;
  rpc_job_t job_data;

  rpc_front #(.MAX_ELEMS(MAX_ELEMS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .job_valid, .job_pop, .job_data
  );

  rpc_scan #(.MAX_ELEMS(MAX_ELEMS)) u_scan (
    .clk, .rst_n, .job_valid, .job_pop, .job_data,
    .out_valid, .out_stall, .out_data
  );

endmodule
